// ===== hdl/arpc_pkg.sv =====
// ----------------------------------------------------------------------------
// ARP cache resolver package
// Shared widths, protocol codes, outcome codes, sequencer states and the
// command struct that the sequencer hands to the cache store.
// ----------------------------------------------------------------------------
package arpc_pkg;

   localparam int ENTRIES_DEFAULT = 8;

   localparam int IP_W        = 32;
   localparam int MAC_W       = 48;
   localparam int AGE_W       = 8;
   localparam int OPCODE_W    = 16;
   localparam int SIZE_W      = 8;
   localparam int OUTCOME_W   = 3;
   localparam int CSR_INDEX_W = 2;

   // Age at which an entry is flushed back to free.
   localparam logic [AGE_W-1:0] AGE_FLUSH = 8'hFF;
   localparam logic [AGE_W-1:0] AGE_FRESH = 8'd1;

   // Input action codes.
   localparam logic ACTION_PACKET = 1'b0;
   localparam logic ACTION_QUERY  = 1'b1;

   // ARP operation codes and the sizes of an Ethernet/IPv4 request.
   localparam logic [OPCODE_W-1:0] OP_REQUEST = 16'd1;
   localparam logic [OPCODE_W-1:0] OP_REPLY   = 16'd2;
   localparam logic [SIZE_W-1:0]   HW_SIZE_ETH     = 8'd6;
   localparam logic [SIZE_W-1:0]   PROTO_SIZE_IPV4 = 8'd4;

   localparam logic [IP_W-1:0]  IP_ALL_ONES  = 32'hFFFF_FFFF;
   localparam logic [MAC_W-1:0] MAC_ALL_ONES = 48'hFFFF_FFFF_FFFF;

   // Result outcome codes.
   localparam logic [OUTCOME_W-1:0] OUT_IGNORED   = 3'd0;
   localparam logic [OUTCOME_W-1:0] OUT_REPLY     = 3'd1;
   localparam logic [OUTCOME_W-1:0] OUT_LEARNED   = 3'd2;
   localparam logic [OUTCOME_W-1:0] OUT_HIT       = 3'd3;
   localparam logic [OUTCOME_W-1:0] OUT_BROADCAST = 3'd4;
   localparam logic [OUTCOME_W-1:0] OUT_MISS      = 3'd5;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_LOCAL_IP    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SUBNET_MASK = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GATEWAY_IP  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT,
      ST_AGE
   } arpc_state_type;

   // Write commands for the cache store; all use the store's write address.
   typedef struct packed {
      logic ip_mac_we;
      logic age_we;
      logic valid_set;
      logic valid_clr;
   } arpc_store_cmd_type;

endpackage

// ===== hdl/arpc_store.sv =====
// ----------------------------------------------------------------------------
// ARP cache store
// Address, MAC and age memories with one write and one registered read port,
// plus a valid flag per entry that reset clears.
// ----------------------------------------------------------------------------
module arpc_store #(
   parameter int ENTRIES = arpc_pkg::ENTRIES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  arpc_pkg::arpc_store_cmd_type     cmd,
   input  logic [$clog2(ENTRIES)-1:0]       wr_addr,
   input  logic [arpc_pkg::IP_W-1:0]        wr_ip,
   input  logic [arpc_pkg::MAC_W-1:0]       wr_mac,
   input  logic [arpc_pkg::AGE_W-1:0]       wr_age,
   input  logic [$clog2(ENTRIES)-1:0]       rd_addr,
   output logic [arpc_pkg::IP_W-1:0]        rd_ip,
   output logic [arpc_pkg::MAC_W-1:0]       rd_mac,
   output logic [arpc_pkg::AGE_W-1:0]       rd_age,
   output logic [ENTRIES-1:0]               valid
);

   logic [arpc_pkg::IP_W-1:0]  ip_mem  [ENTRIES];
   logic [arpc_pkg::MAC_W-1:0] mac_mem [ENTRIES];
   logic [arpc_pkg::AGE_W-1:0] age_mem [ENTRIES];

   logic [arpc_pkg::IP_W-1:0]  rd_ip_ff;
   logic [arpc_pkg::MAC_W-1:0] rd_mac_ff;
   logic [arpc_pkg::AGE_W-1:0] rd_age_ff;
   logic [ENTRIES-1:0]         valid_ff;
   logic [ENTRIES-1:0]         valid_in;

   always_ff @(posedge clock) begin
      if (cmd.ip_mac_we) begin
         ip_mem[wr_addr]  <= wr_ip;
         mac_mem[wr_addr] <= wr_mac;
      end
      if (cmd.age_we) begin
         age_mem[wr_addr] <= wr_age;
      end
      rd_ip_ff  <= ip_mem[rd_addr];
      rd_mac_ff <= mac_mem[rd_addr];
      rd_age_ff <= age_mem[rd_addr];
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.valid_set) begin
         valid_in[wr_addr] = 1'b1;
      end else if (cmd.valid_clr) begin
         valid_in[wr_addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd_ip  = rd_ip_ff;
   assign rd_mac = rd_mac_ff;
   assign rd_age = rd_age_ff;
   assign valid  = valid_ff;

endmodule

// ===== hdl/arp_cache_resolver.sv =====
// ----------------------------------------------------------------------------
// ARP cache resolver
// IPv4-to-MAC cache with age-based replacement, serving parsed ARP packets
// and resolve queries one transaction at a time.
// ----------------------------------------------------------------------------
// Usage:
// A transaction is accepted on the rising edge where start is high and busy
// is low; the req_ ports carry either parsed ARP packet fields (action 0) or
// a resolve query (action 1). Every transaction gives exactly one result on
// the rsp_ ports, shown for a single cycle while rsp_valid is high. The
// receiver cannot stall, so the result must be taken in that cycle.
// Requests, broadcast queries and ignored opcodes answer in the cycle after
// acceptance, and busy never rises for them.
// A query that needs a lookup scans the cache one entry per cycle through
// the single read port of the cache memories, then shows its result. A
// reply scans, writes the chosen entry and then walks the cache again to
// age the written entry and every valid one before it shows its result.
// The next transaction may start in the cycle that shows the result.
// The csr_ channel writes local_ip, subnet_mask and gateway_ip; csr_ready is
// always high, and writes are expected only while the block is idle.
// Synchronous reset marks every entry free and clears the registers; no
// clearing pass is needed, so the block is ready right after reset.
// ----------------------------------------------------------------------------
module arp_cache_resolver #(
   parameter int CACHE_ENTRIES = arpc_pkg::ENTRIES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // Transaction request.
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_action,
   input  logic [arpc_pkg::OPCODE_W-1:0]       req_opcode,
   input  logic [arpc_pkg::SIZE_W-1:0]         req_hw_size,
   input  logic [arpc_pkg::SIZE_W-1:0]         req_proto_size,
   input  logic [arpc_pkg::MAC_W-1:0]          req_sender_mac,
   input  logic [arpc_pkg::IP_W-1:0]           req_sender_ip,
   input  logic [arpc_pkg::IP_W-1:0]           req_target_ip,
   input  logic [arpc_pkg::IP_W-1:0]           req_query_ip,
   // Result.
   output logic                                rsp_valid,
   output logic [arpc_pkg::OUTCOME_W-1:0]      rsp_outcome,
   output logic [arpc_pkg::MAC_W-1:0]          rsp_result_mac,
   output logic [arpc_pkg::IP_W-1:0]           rsp_result_ip,
   // Configuration writes.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [arpc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [arpc_pkg::IP_W-1:0]           csr_data
);

   localparam int IDX_W = $clog2(CACHE_ENTRIES);
   localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CACHE_ENTRIES);

   arpc_pkg::arpc_state_type state_ff, state_in;

   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic                           learn_ff, learn_in;
   logic [arpc_pkg::IP_W-1:0]      key_ff, key_in;
   logic [arpc_pkg::MAC_W-1:0]     mac_key_ff, mac_key_in;
   logic                           hit_found_ff, hit_found_in;
   logic [IDX_W-1:0]               hit_idx_ff, hit_idx_in;
   logic [arpc_pkg::MAC_W-1:0]     hit_mac_ff, hit_mac_in;
   logic                           free_found_ff, free_found_in;
   logic [IDX_W-1:0]               free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]               max_idx_ff, max_idx_in;
   logic [arpc_pkg::AGE_W-1:0]     max_age_ff, max_age_in;
   logic [IDX_W-1:0]               slot_ff, slot_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [arpc_pkg::OUTCOME_W-1:0] rsp_outcome_ff, rsp_outcome_in;
   logic [arpc_pkg::MAC_W-1:0]     rsp_mac_ff, rsp_mac_in;
   logic [arpc_pkg::IP_W-1:0]      rsp_ip_ff, rsp_ip_in;

   logic [arpc_pkg::IP_W-1:0]      local_ip_ff, subnet_mask_ff, gateway_ip_ff;

   // Cache store interface.
   arpc_pkg::arpc_store_cmd_type   store_cmd;
   logic [IDX_W-1:0]               store_wr_addr;
   logic [arpc_pkg::AGE_W-1:0]     store_wr_age;
   logic [IDX_W-1:0]               store_rd_addr;
   logic [arpc_pkg::IP_W-1:0]      store_rd_ip;
   logic [arpc_pkg::MAC_W-1:0]     store_rd_mac;
   logic [arpc_pkg::AGE_W-1:0]     store_rd_age;
   logic [CACHE_ENTRIES-1:0]       store_valid;

   // Shared compare unit operands: the entry whose read data arrives now.
   logic [IDX_W-1:0]               proc_idx;
   logic                           proc_valid;
   logic                           proc_match;
   logic                           proc_is_slot;
   logic [arpc_pkg::AGE_W-1:0]     cur_age;
   logic [arpc_pkg::AGE_W:0]       age_sum;
   logic                           age_flush;
   logic                           size_ok;
   logic                           off_subnet;

   arpc_store #(
      .ENTRIES (CACHE_ENTRIES)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (store_cmd),
      .wr_addr (store_wr_addr),
      .wr_ip   (key_ff),
      .wr_mac  (mac_key_ff),
      .wr_age  (store_wr_age),
      .rd_addr (store_rd_addr),
      .rd_ip   (store_rd_ip),
      .rd_mac  (store_rd_mac),
      .rd_age  (store_rd_age),
      .valid   (store_valid)
   );

   // Read data arrives in the cycle after its address is issued, so the entry
   // being compared is one behind the counter.
   assign proc_idx      = IDX_W'(cnt_ff - CNT_W'(1));
   assign proc_valid    = store_valid[proc_idx];
   assign proc_match    = proc_valid && (store_rd_ip == key_ff);
   assign proc_is_slot  = (proc_idx == slot_ff);
   assign cur_age       = proc_is_slot ? arpc_pkg::AGE_FRESH : store_rd_age;
   assign age_sum       = {1'b0, cur_age} + {{arpc_pkg::AGE_W{1'b0}}, 1'b1};
   assign age_flush     = (age_sum >= {1'b0, arpc_pkg::AGE_FLUSH});
   assign store_wr_age  = age_sum[arpc_pkg::AGE_W-1:0];
   assign store_rd_addr = (cnt_ff < CNT_LAST) ? cnt_ff[IDX_W-1:0] : '0;

   assign size_ok = (req_hw_size == arpc_pkg::HW_SIZE_ETH) &&
                    (req_proto_size == arpc_pkg::PROTO_SIZE_IPV4);
   assign off_subnet = ((req_query_ip & subnet_mask_ff) !=
                        (local_ip_ff & subnet_mask_ff));

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      learn_in       = learn_ff;
      key_in         = key_ff;
      mac_key_in     = mac_key_ff;
      hit_found_in   = hit_found_ff;
      hit_idx_in     = hit_idx_ff;
      hit_mac_in     = hit_mac_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      max_idx_in     = max_idx_ff;
      max_age_in     = max_age_ff;
      slot_in        = slot_ff;
      rsp_valid_in   = 1'b0;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_mac_in     = rsp_mac_ff;
      rsp_ip_in      = rsp_ip_ff;
      store_cmd      = '0;
      store_wr_addr  = proc_idx;

      case (state_ff)
         arpc_pkg::ST_IDLE: begin
            if (start) begin
               cnt_in         = '0;
               hit_found_in   = 1'b0;
               free_found_in  = 1'b0;
               mac_key_in     = req_sender_mac;
               rsp_outcome_in = arpc_pkg::OUT_IGNORED;
               rsp_mac_in     = '0;
               rsp_ip_in      = '0;
               if (req_action == arpc_pkg::ACTION_QUERY) begin
                  if (req_query_ip == arpc_pkg::IP_ALL_ONES) begin
                     rsp_valid_in   = 1'b1;
                     rsp_outcome_in = arpc_pkg::OUT_BROADCAST;
                     rsp_mac_in     = arpc_pkg::MAC_ALL_ONES;
                  end else begin
                     learn_in = 1'b0;
                     key_in   = off_subnet ? gateway_ip_ff : req_query_ip;
                     state_in = arpc_pkg::ST_SCAN;
                  end
               end else if (req_opcode == arpc_pkg::OP_REPLY) begin
                  learn_in = 1'b1;
                  key_in   = req_sender_ip;
                  state_in = arpc_pkg::ST_SCAN;
               end else begin
                  rsp_valid_in = 1'b1;
                  if (req_opcode == arpc_pkg::OP_REQUEST && size_ok &&
                      req_target_ip == local_ip_ff) begin
                     rsp_outcome_in = arpc_pkg::OUT_REPLY;
                     rsp_mac_in     = req_sender_mac;
                     rsp_ip_in      = req_sender_ip;
                  end
               end
            end
         end

         arpc_pkg::ST_SCAN: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff != '0) begin
               if (!hit_found_ff && proc_match) begin
                  hit_found_in = 1'b1;
                  hit_idx_in   = proc_idx;
                  hit_mac_in   = store_rd_mac;
               end
               if (!free_found_ff && !proc_valid) begin
                  free_found_in = 1'b1;
                  free_idx_in   = proc_idx;
               end
               // Oldest entry, lowest index on ties; only used when full.
               if (proc_idx == '0 || store_rd_age > max_age_ff) begin
                  max_idx_in = proc_idx;
                  max_age_in = store_rd_age;
               end
            end
            if (cnt_ff == CNT_LAST) begin
               if (learn_ff) begin
                  if (hit_found_in) begin
                     slot_in = hit_idx_in;
                  end else if (free_found_in) begin
                     slot_in = free_idx_in;
                  end else begin
                     slot_in = max_idx_in;
                  end
                  state_in = arpc_pkg::ST_COMMIT;
               end else begin
                  rsp_valid_in = 1'b1;
                  if (hit_found_in) begin
                     rsp_outcome_in = arpc_pkg::OUT_HIT;
                     rsp_mac_in     = hit_mac_in;
                  end else begin
                     rsp_outcome_in = arpc_pkg::OUT_MISS;
                     rsp_ip_in      = key_ff;
                  end
                  state_in = arpc_pkg::ST_IDLE;
               end
            end
         end

         arpc_pkg::ST_COMMIT: begin
            // A hit keeps its binding; a new binding overwrites the slot.
            store_cmd.ip_mac_we = !hit_found_ff;
            store_wr_addr       = slot_ff;
            cnt_in              = '0;
            state_in            = arpc_pkg::ST_AGE;
         end

         arpc_pkg::ST_AGE: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff != '0 && (proc_valid || proc_is_slot)) begin
               store_cmd.age_we    = !age_flush;
               store_cmd.valid_set = !age_flush;
               store_cmd.valid_clr = age_flush;
            end
            if (cnt_ff == CNT_LAST) begin
               rsp_valid_in   = 1'b1;
               rsp_outcome_in = arpc_pkg::OUT_LEARNED;
               state_in       = arpc_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = arpc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= arpc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff         <= cnt_in;
      learn_ff       <= learn_in;
      key_ff         <= key_in;
      mac_key_ff     <= mac_key_in;
      hit_found_ff   <= hit_found_in;
      hit_idx_ff     <= hit_idx_in;
      hit_mac_ff     <= hit_mac_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      max_idx_ff     <= max_idx_in;
      max_age_ff     <= max_age_in;
      slot_ff        <= slot_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_mac_ff     <= rsp_mac_in;
      rsp_ip_ff      <= rsp_ip_in;
   end

   // Configuration registers; an index beyond the list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         local_ip_ff    <= '0;
         subnet_mask_ff <= '0;
         gateway_ip_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            arpc_pkg::CSR_LOCAL_IP:    local_ip_ff    <= csr_data;
            arpc_pkg::CSR_SUBNET_MASK: subnet_mask_ff <= csr_data;
            arpc_pkg::CSR_GATEWAY_IP:  gateway_ip_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign csr_ready      = 1'b1;
   assign busy           = (state_ff != arpc_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_outcome    = rsp_outcome_ff;
   assign rsp_result_mac = rsp_mac_ff;
   assign rsp_result_ip  = rsp_ip_ff;

`ifndef SYNTHESIS
   // A result is only shown once the sequencer has returned to idle.
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while the sequencer is busy");

   // Every accepted transaction either answers at once or starts a scan.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted transaction neither answered nor started");

   // The entry written by a reply is still valid after the aging walk.
   a_slot_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == arpc_pkg::ST_AGE && state_in == arpc_pkg::ST_IDLE)
      |=> store_valid[slot_ff])
      else $error("learned entry not valid after aging");

   // The walk counter never runs past the last entry.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == arpc_pkg::ST_SCAN || state_ff == arpc_pkg::ST_AGE)
      |-> (cnt_ff <= CNT_LAST))
      else $error("cache walk counter out of range");
`endif

endmodule

// ===== verif/arp_cache_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache resolver checker
// Watches the request, result and configuration channels of the resolver,
// keeps its own copy of the cache and the registers, and compares every
// result with the answer predicted when its transaction was accepted.
// ----------------------------------------------------------------------------
module arp_cache_checker #(
   parameter int CACHE_ENTRIES = arpc_pkg::ENTRIES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  logic                             req_action,
   input  logic [arpc_pkg::OPCODE_W-1:0]    req_opcode,
   input  logic [arpc_pkg::SIZE_W-1:0]      req_hw_size,
   input  logic [arpc_pkg::SIZE_W-1:0]      req_proto_size,
   input  logic [arpc_pkg::MAC_W-1:0]       req_sender_mac,
   input  logic [arpc_pkg::IP_W-1:0]        req_sender_ip,
   input  logic [arpc_pkg::IP_W-1:0]        req_target_ip,
   input  logic [arpc_pkg::IP_W-1:0]        req_query_ip,
   input  logic                             rsp_valid,
   input  logic [arpc_pkg::OUTCOME_W-1:0]   rsp_outcome,
   input  logic [arpc_pkg::MAC_W-1:0]       rsp_result_mac,
   input  logic [arpc_pkg::IP_W-1:0]        rsp_result_ip,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [arpc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [arpc_pkg::IP_W-1:0]        csr_data,
   output int                               fail_count,
   output int                               pending
);

   import arpc_pkg::*;

   typedef struct packed {
      logic [OUTCOME_W-1:0] outcome;
      logic [MAC_W-1:0]     mac;
      logic [IP_W-1:0]      ip;
   } arp_answer_t;

   logic [AGE_W-1:0] age_q    [CACHE_ENTRIES];
   logic [IP_W-1:0]  bind_ip  [CACHE_ENTRIES];
   logic [MAC_W-1:0] bind_mac [CACHE_ENTRIES];
   logic [IP_W-1:0]  local_ip_q;
   logic [IP_W-1:0]  mask_q;
   logic [IP_W-1:0]  gateway_q;

   arp_answer_t expected_answers [$];
   int mismatches = 0;
   int waiting = 0;

   assign fail_count = mismatches;
   assign pending    = waiting;

   // Only entries with a nonzero age take part in a lookup.
   function automatic int find_binding(input logic [IP_W-1:0] addr);
      for (int k = 0; k < CACHE_ENTRIES; k++) begin
         if (age_q[k] != '0 && bind_ip[k] == addr) begin
            return k;
         end
      end
      return -1;
   endfunction

   function automatic void learn_binding(input logic [IP_W-1:0] ip,
                                         input logic [MAC_W-1:0] mac);
      int slot;
      logic [AGE_W:0] next_age;
      slot = find_binding(ip);
      if (slot >= 0) begin
         // A known sender only gets its age refreshed; the MAC stays.
         age_q[slot] = AGE_FRESH;
      end else begin
         for (int k = CACHE_ENTRIES - 1; k >= 0; k--) begin
            if (age_q[k] == '0) begin
               slot = k;
            end
         end
         if (slot < 0) begin
            slot = 0;
            for (int k = 1; k < CACHE_ENTRIES; k++) begin
               if (age_q[k] > age_q[slot]) begin
                  slot = k;
               end
            end
         end
         age_q[slot]    = AGE_FRESH;
         bind_ip[slot]  = ip;
         bind_mac[slot] = mac;
      end
      for (int k = 0; k < CACHE_ENTRIES; k++) begin
         if (age_q[k] != '0) begin
            next_age = {1'b0, age_q[k]} + 1'b1;
            age_q[k] = (next_age >= AGE_FLUSH) ? '0 : next_age[AGE_W-1:0];
         end
      end
   endfunction

   function automatic arp_answer_t predict_answer();
      arp_answer_t ans;
      logic [IP_W-1:0] addr;
      int hit;
      ans = '0;
      ans.outcome = OUT_IGNORED;
      if (req_action == ACTION_PACKET) begin
         if (req_opcode == OP_REQUEST) begin
            if (req_hw_size == HW_SIZE_ETH && req_proto_size == PROTO_SIZE_IPV4 &&
                req_target_ip == local_ip_q) begin
               ans.outcome = OUT_REPLY;
               ans.mac     = req_sender_mac;
               ans.ip      = req_sender_ip;
            end
         end else if (req_opcode == OP_REPLY) begin
            learn_binding(req_sender_ip, req_sender_mac);
            ans.outcome = OUT_LEARNED;
         end
      end else if (req_query_ip == IP_ALL_ONES) begin
         ans.outcome = OUT_BROADCAST;
         ans.mac     = MAC_ALL_ONES;
      end else begin
         addr = req_query_ip;
         if ((addr & mask_q) != (local_ip_q & mask_q)) begin
            addr = gateway_q;
         end
         hit = find_binding(addr);
         if (hit >= 0) begin
            ans.outcome = OUT_HIT;
            ans.mac     = bind_mac[hit];
         end else begin
            ans.outcome = OUT_MISS;
            ans.ip      = addr;
         end
      end
      return ans;
   endfunction

   function automatic void check_field(input string name, input logic [MAC_W-1:0] want,
                                       input logic [MAC_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      arp_answer_t want;
      if (reset) begin
         for (int k = 0; k < CACHE_ENTRIES; k++) begin
            age_q[k]    = '0;
            bind_ip[k]  = '0;
            bind_mac[k] = '0;
         end
         local_ip_q = '0;
         mask_q     = '0;
         gateway_q  = '0;
         expected_answers.delete();
      end else begin
         // The result shown in this cycle always belongs to an older
         // transaction, so it is checked before a new one is predicted.
         if (rsp_valid) begin
            if (expected_answers.size() == 0) begin
               $display("%0t: unexpected result, outcome %0d mac %h ip %h", $time,
                        rsp_outcome, rsp_result_mac, rsp_result_ip);
               mismatches++;
            end else begin
               want = expected_answers.pop_front();
               check_field("outcome", MAC_W'(want.outcome), MAC_W'(rsp_outcome));
               check_field("result_mac", want.mac, rsp_result_mac);
               check_field("result_ip", MAC_W'(want.ip), MAC_W'(rsp_result_ip));
            end
         end
         if (start && !busy) begin
            expected_answers.push_back(predict_answer());
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LOCAL_IP:    local_ip_q = csr_data;
               CSR_SUBNET_MASK: mask_q     = csr_data;
               CSR_GATEWAY_IP:  gateway_q  = csr_data;
               default: ;
            endcase
         end
      end
      waiting = expected_answers.size();
   end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache resolver testbench
// Drives parsed ARP packets and resolve queries into the resolver under
// several register settings, from a directed opening through random phases
// that fill, evict and finally age out cache entries. A checker beside the
// block predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;

   import arpc_pkg::*;

   localparam int ENTRIES = ENTRIES_DEFAULT;
   // A learning reply is the slowest transaction of the block.
   localparam int REPLY_CYCLES = 2 * ENTRIES + 4;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int POOL_SIZE    = 12;

   // Index 3 is not a register; writes to it must be dropped.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   // Opcodes that the block is expected to ignore.
   localparam logic [OPCODE_W-1:0] OP_NONE         = 16'd0;
   localparam logic [OPCODE_W-1:0] OP_RARP_REQUEST = 16'd3;
   localparam logic [OPCODE_W-1:0] OP_ALL_ONES     = 16'hFFFF;

   // Register setting and addresses for the directed opening.
   localparam logic [IP_W-1:0] DIR_LOCAL   = 32'hC0A8_0105;
   localparam logic [IP_W-1:0] DIR_MASK    = 32'hFFFF_FF00;
   localparam logic [IP_W-1:0] DIR_GATEWAY = 32'hC0A8_01FE;
   localparam logic [IP_W-1:0] DIR_HOST    = 32'hC0A8_0142;
   localparam logic [IP_W-1:0] DIR_REMOTE  = 32'h0808_0808;

   typedef struct {
      logic                action;
      logic [OPCODE_W-1:0] opcode;
      logic [SIZE_W-1:0]   hw_size;
      logic [SIZE_W-1:0]   proto_size;
      logic [MAC_W-1:0]    sender_mac;
      logic [IP_W-1:0]     sender_ip;
      logic [IP_W-1:0]     target_ip;
      logic [IP_W-1:0]     query_ip;
   } arp_item_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic                   req_action = 1'b0;
   logic [OPCODE_W-1:0]    req_opcode = '0;
   logic [SIZE_W-1:0]      req_hw_size = '0;
   logic [SIZE_W-1:0]      req_proto_size = '0;
   logic [MAC_W-1:0]       req_sender_mac = '0;
   logic [IP_W-1:0]        req_sender_ip = '0;
   logic [IP_W-1:0]        req_target_ip = '0;
   logic [IP_W-1:0]        req_query_ip = '0;
   logic                   rsp_valid;
   logic [OUTCOME_W-1:0]   rsp_outcome;
   logic [MAC_W-1:0]       rsp_result_mac;
   logic [IP_W-1:0]        rsp_result_ip;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [IP_W-1:0]        csr_data = '0;

   int fail_count;
   int pending;
   int cycle_count;
   int sender_idle_pct = 0;

   // Addresses used by the well-formed traffic of the current phase: the
   // gateway, this station, and hosts on the local subnet.
   logic [IP_W-1:0] neighbor_ip [POOL_SIZE];

   arp_cache_resolver #(
      .CACHE_ENTRIES(ENTRIES)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_action    (req_action),
      .req_opcode    (req_opcode),
      .req_hw_size   (req_hw_size),
      .req_proto_size(req_proto_size),
      .req_sender_mac(req_sender_mac),
      .req_sender_ip (req_sender_ip),
      .req_target_ip (req_target_ip),
      .req_query_ip  (req_query_ip),
      .rsp_valid     (rsp_valid),
      .rsp_outcome   (rsp_outcome),
      .rsp_result_mac(rsp_result_mac),
      .rsp_result_ip (rsp_result_ip),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   arp_cache_checker #(
      .CACHE_ENTRIES(ENTRIES)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_action    (req_action),
      .req_opcode    (req_opcode),
      .req_hw_size   (req_hw_size),
      .req_proto_size(req_proto_size),
      .req_sender_mac(req_sender_mac),
      .req_sender_ip (req_sender_ip),
      .req_target_ip (req_target_ip),
      .req_query_ip  (req_query_ip),
      .rsp_valid     (rsp_valid),
      .rsp_outcome   (rsp_outcome),
      .rsp_result_mac(rsp_result_mac),
      .rsp_result_ip (rsp_result_ip),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending       (pending)
   );

   always #1 clock = ~clock;

   // Watchdog: a run that stops making progress ends here as a failure.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("arp_cache_resolver test failed");
      $finish;
   end

   function automatic logic [MAC_W-1:0] rand_mac();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[MAC_W-1:0];
   endfunction

   // Every field random, the action included; most of these are ignored
   // packets or queries of random addresses.
   function automatic arp_item_t rand_item();
      arp_item_t it;
      it.action     = 1'($urandom_range(1));
      it.opcode     = OPCODE_W'($urandom);
      it.hw_size    = SIZE_W'($urandom);
      it.proto_size = SIZE_W'($urandom);
      it.sender_mac = rand_mac();
      it.sender_ip  = $urandom;
      it.target_ip  = $urandom;
      it.query_ip   = $urandom;
      return it;
   endfunction

   // Presents one transaction and returns once it has been accepted. Inputs
   // change on the falling edge only. Busy is read right after the rising
   // edge, before the block's own updates of that edge take effect, which
   // is the value the block itself acts on. Start stays high between
   // back-to-back transactions instead of being lowered and raised again.
   task automatic issue(input arp_item_t it);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start          <= 1'b1;
      req_action     <= it.action;
      req_opcode     <= it.opcode;
      req_hw_size    <= it.hw_size;
      req_proto_size <= it.proto_size;
      req_sender_mac <= it.sender_mac;
      req_sender_ip  <= it.sender_ip;
      req_target_ip  <= it.target_ip;
      req_query_ip   <= it.query_ip;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic send_packet(input logic [OPCODE_W-1:0] op, input logic [SIZE_W-1:0] hw,
                              input logic [SIZE_W-1:0] proto, input logic [MAC_W-1:0] mac,
                              input logic [IP_W-1:0] sip, input logic [IP_W-1:0] tip);
      arp_item_t it;
      it            = rand_item();
      it.action     = ACTION_PACKET;
      it.opcode     = op;
      it.hw_size    = hw;
      it.proto_size = proto;
      it.sender_mac = mac;
      it.sender_ip  = sip;
      it.target_ip  = tip;
      issue(it);
   endtask

   task automatic send_query(input logic [IP_W-1:0] ip);
      arp_item_t it;
      it          = rand_item();
      it.action   = ACTION_QUERY;
      it.query_ip = ip;
      issue(it);
   endtask

   // Stops the sender until every outstanding result has come back and the
   // block has dropped busy, then lets a reply's worth of cycles go by.
   task automatic drain_results();
      start <= 1'b0;
      do @(negedge clock); while (pending != 0 || busy);
      repeat (REPLY_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [IP_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // The write to the unused index carries a value that would break the
   // request checks if it landed in the local address register.
   task automatic set_config(input logic [IP_W-1:0] lip, input logic [IP_W-1:0] msk,
                             input logic [IP_W-1:0] gw);
      write_csr(CSR_LOCAL_IP, lip);
      write_csr(CSR_UNUSED, ~lip);
      write_csr(CSR_SUBNET_MASK, msk);
      write_csr(CSR_GATEWAY_IP, gw);
      csr_valid <= 1'b0;
   endtask

   // One random phase. The mixed part is mostly well-formed traffic among
   // the neighbor addresses, with noise. The hot part then keeps learning
   // only two senders, so every other entry ages until it is flushed; the
   // closing sweep of queries shows which entries are still cached.
   task automatic run_phase(input logic [IP_W-1:0] lip, input logic [IP_W-1:0] msk,
                            input logic [IP_W-1:0] gw, input int idle, input int count,
                            input int hot);
      int r;
      drain_results();
      set_config(lip, msk, gw);
      sender_idle_pct = idle;
      neighbor_ip[0] = gw;
      neighbor_ip[1] = lip;
      for (int k = 2; k < POOL_SIZE; k++) begin
         neighbor_ip[k] = (lip & msk) | ($urandom & ~msk);
      end
      for (int n = 0; n < count; n++) begin
         // Now and then the sender waits for the block to go fully idle.
         if ($urandom_range(39) == 0) begin
            drain_results();
         end
         r = $urandom_range(99);
         if (r < 30) begin
            send_packet(OP_REPLY, HW_SIZE_ETH, PROTO_SIZE_IPV4, rand_mac(),
                        neighbor_ip[$urandom_range(POOL_SIZE - 1)], $urandom);
         end else if (r < 52) begin
            send_query(neighbor_ip[$urandom_range(POOL_SIZE - 1)]);
         end else if (r < 58) begin
            send_query(IP_ALL_ONES);
         end else if (r < 66) begin
            send_query($urandom);
         end else if (r < 80) begin
            send_packet(OP_REQUEST,
                        ($urandom_range(4) == 0) ? SIZE_W'($urandom) : HW_SIZE_ETH,
                        ($urandom_range(4) == 0) ? SIZE_W'($urandom) : PROTO_SIZE_IPV4,
                        rand_mac(), $urandom,
                        ($urandom_range(3) == 0) ? $urandom : lip);
         end else if (r < 88) begin
            // Replies learn whatever their size bytes say.
            send_packet(OP_REPLY, SIZE_W'($urandom), SIZE_W'($urandom), rand_mac(),
                        $urandom, $urandom);
         end else begin
            issue(rand_item());
         end
      end
      for (int n = 0; n < hot; n++) begin
         r = $urandom_range(99);
         if (r < 88) begin
            send_packet(OP_REPLY, HW_SIZE_ETH, PROTO_SIZE_IPV4, rand_mac(),
                        neighbor_ip[2 + $urandom_range(1)], $urandom);
         end else if (r < 96) begin
            send_query(neighbor_ip[$urandom_range(POOL_SIZE - 1)]);
         end else begin
            send_packet(OP_REQUEST, HW_SIZE_ETH, PROTO_SIZE_IPV4, rand_mac(), $urandom, lip);
         end
      end
      for (int k = 0; k < POOL_SIZE; k++) begin
         send_query(neighbor_ip[k]);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed opening on a typical /24 setting.
      set_config(DIR_LOCAL, DIR_MASK, DIR_GATEWAY);
      sender_idle_pct = 10;
      // Empty cache: a local lookup misses, all ones is broadcast.
      send_query(DIR_HOST);
      send_query(IP_ALL_ONES);
      // A request answers only with Ethernet/IPv4 sizes and our address.
      send_packet(OP_REQUEST, HW_SIZE_ETH, PROTO_SIZE_IPV4, MAC_ALL_ONES, '0, DIR_LOCAL);
      send_packet(OP_REQUEST, 8'd5, PROTO_SIZE_IPV4, rand_mac(), $urandom, DIR_LOCAL);
      send_packet(OP_REQUEST, HW_SIZE_ETH, 8'd255, rand_mac(), $urandom, DIR_LOCAL);
      send_packet(OP_REQUEST, HW_SIZE_ETH, PROTO_SIZE_IPV4, rand_mac(), $urandom,
                  DIR_LOCAL ^ 32'h1);
      // Opcodes other than request and reply change nothing.
      send_packet(OP_NONE, HW_SIZE_ETH, PROTO_SIZE_IPV4, rand_mac(), DIR_HOST, DIR_LOCAL);
      send_packet(OP_ALL_ONES, HW_SIZE_ETH, PROTO_SIZE_IPV4, rand_mac(), DIR_HOST, DIR_LOCAL);
      send_packet(OP_RARP_REQUEST, HW_SIZE_ETH, PROTO_SIZE_IPV4, rand_mac(), DIR_HOST,
                  DIR_LOCAL);
      // A reply with odd size bytes still learns; a second reply from the
      // same sender refreshes its age but keeps the first MAC.
      send_packet(OP_REPLY, 8'd0, 8'd255, 48'h1, DIR_HOST, $urandom);
      send_query(DIR_HOST);
      send_packet(OP_REPLY, HW_SIZE_ETH, PROTO_SIZE_IPV4, 48'h2, DIR_HOST, $urandom);
      send_query(DIR_HOST);
      // Off-subnet addresses go to the gateway: miss, learn, then hit.
      send_query(DIR_REMOTE);
      send_packet(OP_REPLY, HW_SIZE_ETH, PROTO_SIZE_IPV4, rand_mac(), DIR_GATEWAY, $urandom);
      send_query(DIR_REMOTE);
      // Seven more senders overfill the cache, so the oldest entry goes.
      for (int k = 0; k < 7; k++) begin
         send_packet(OP_REPLY, HW_SIZE_ETH, PROTO_SIZE_IPV4, rand_mac(),
                     DIR_LOCAL + 32'h10 + IP_W'(k), $urandom);
      end
      send_query(DIR_HOST);
      send_query(DIR_LOCAL & DIR_MASK);

      // Random phases: sender idles seldom, then often, then never. The
      // register extremes come in the middle; the last phase ages entries
      // out while nothing else touches them.
      run_phase($urandom, 32'hFFFF_0000, $urandom, 10, 40, 0);
      run_phase(IP_ALL_ONES, '0, IP_ALL_ONES, 53, 30, 0);
      run_phase('0, IP_ALL_ONES, '0, 53, 20, 0);
      run_phase($urandom, DIR_MASK, $urandom, 0, 10, 300);

      drain_results();
      if (fail_count == 0 && pending == 0) begin
         $display("arp_cache_resolver test passed");
      end else begin
         $display("arp_cache_resolver test failed");
      end
      $finish;
   end

endmodule
